>>> rtl/core/assert_macros.svh
// Assertion helper macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Assert a property on the rising clock edge, held off during reset.
`define ASSERT_CLK(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");
// Assert a property that also holds during reset.
`define ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) prop) else $error("assertion failed");
`endif

>>> rtl/core/drti_pkg.sv
// ----------------------------------------------------------------------------
// drti_pkg
// Shared constants and types for the binary64 round-to-integral core.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
package drti_pkg;

  localparam int unsigned DataW = 64;

  localparam logic [63:0] FracMask = 64'h000F_FFFF_FFFF_FFFF;
  localparam logic [63:0] HalfBit  = 64'h0008_0000_0000_0000;
  localparam logic [63:0] CanonNan = 64'h7FF8_0000_0000_0000;
  localparam logic [63:0] SignBit  = 64'h8000_0000_0000_0000;
  localparam logic [63:0] OneBits  = 64'h3FF0_0000_0000_0000;
  localparam logic [10:0] ExpBias  = 11'd1023;
  localparam logic [10:0] ExpMax   = 11'h7FF;

  typedef enum logic [1:0] {
    ModeFloor = 2'd0,
    ModeCeil  = 2'd1,
    ModeTrunc = 2'd2,
    ModeRound = 2'd3
  } mode_e;

endpackage

>>> rtl/core/double_round_to_integral_core.sv
// ----------------------------------------------------------------------------
// double_round_to_integral_core
// Rounds a binary64 value to an integral value: floor, ceil, trunc, round.
// ----------------------------------------------------------------------------
// One beat in, one beat out. The operand is captured in an input register,
// rounded by a single pass of mask, compare and 64-bit increment logic, and
// the result held in an output register; a taken beat passes through both
// registers in turn. One beat can be taken every cycle while the output side
// keeps taking results. NaN inputs give the canonical quiet NaN.
`timescale 1ns / 1ps
module double_round_to_integral_core (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic [1:0]               action_i,
  input  logic [drti_pkg::DataW-1:0] value_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic [drti_pkg::DataW-1:0] result_o
);
  import drti_pkg::*;

  logic              s1_valid_q;
  logic [1:0]        s1_mode_q;
  logic [DataW-1:0]  s1_value_q;
  logic              out_valid_q;
  logic [DataW-1:0]  out_data_q;
  logic [DataW-1:0]  res_d;
  logic              s1_adv;
  logic              out_free;

  // Advance when the next stage has room
  assign out_free   = !out_valid_q || out_ready_i;
  assign s1_adv     = s1_valid_q && out_free;
  assign in_ready_o = !s1_valid_q || out_free;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      s1_mode_q  <= action_i;
      s1_value_q <= value_i;
    end
  end

  // Round in one pass
  logic [10:0]      exp_raw;
  logic [10:0]      e_ub;
  logic [5:0]       e_sh;
  logic [DataW-1:0] fmask;
  logic [DataW-1:0] half;
  logic [DataW-1:0] ulp;
  logic [DataW-1:0] sign;
  logic             neg;
  logic             up;
  mode_e            mode;

  always_comb begin
    exp_raw = s1_value_q[62:52];
    e_ub    = exp_raw - ExpBias;
    e_sh    = e_ub[5:0];
    sign    = s1_value_q & SignBit;
    neg     = s1_value_q[63];
    mode    = mode_e'(s1_mode_q);
    fmask   = FracMask >> e_sh;
    half    = HalfBit >> e_sh;
    ulp     = fmask + 64'd1;
    up      = 1'b0;
    res_d   = s1_value_q;
    if (s1_value_q[62:0] == 63'd0) begin
      res_d = s1_value_q;
    end else if (exp_raw == ExpMax) begin
      res_d = ((s1_value_q & FracMask) != '0) ? CanonNan : s1_value_q;
    end else if (exp_raw >= 11'd1075) begin
      res_d = s1_value_q;
    end else if (exp_raw < ExpBias) begin
      case (mode)
        ModeFloor: res_d = neg ? (SignBit | OneBits) : sign;
        ModeCeil:  res_d = neg ? SignBit : OneBits;
        ModeTrunc: res_d = sign;
        default:   res_d = (exp_raw == 11'd1022) ? (sign | OneBits) : sign;
      endcase
    end else if ((s1_value_q & fmask) == '0) begin
      res_d = s1_value_q;
    end else begin
      case (mode)
        ModeFloor: up = neg;
        ModeCeil:  up = !neg;
        ModeTrunc: up = 1'b0;
        default:   up = (s1_value_q & half) != '0;
      endcase
      res_d = (s1_value_q & ~fmask) + (up ? ulp : '0);
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      out_data_q <= res_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign result_o    = out_data_q;

endmodule

>>> rtl/core/drti_checker.sv
// ----------------------------------------------------------------------------
// drti_checker
// Port-level checks for the round-to-integral core, bound to the core module.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"
module drti_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [63:0] result_o
);
  // Hold a stalled result
  `ASSERT_CLK(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i |=> out_valid_o && $stable(result_o))
  // Accept while the output drains
  `ASSERT_CLK(a_ready_drain, clk_i, rst_ni, out_ready_i |-> in_ready_o)
  // A beat taken reaches the output when out_ready_i is high after the accept
  `ASSERT_CLK(a_latency, clk_i, rst_ni, in_valid_i && in_ready_o ##1 out_ready_i |=> out_valid_o)
  // No result straight out of reset
  `ASSERT_ALWAYS(a_reset_idle, clk_i, !rst_ni |-> !out_valid_o)
endmodule

bind double_round_to_integral_core drti_checker u_drti_checker (
  .clk_i(clk_i), .rst_ni(rst_ni), .in_valid_i(in_valid_i), .in_ready_o(in_ready_o),
  .out_valid_o(out_valid_o), .out_ready_i(out_ready_i), .result_o(result_o)
);

>>> sim/double_round_to_integral_core_tb.sv
// ----------------------------------------------------------------------------
// double_round_to_integral_core_tb
// Checks the binary64 round-to-integral core against a bit-exact predictor.
// ----------------------------------------------------------------------------
// Directed operands (zeros, infinities, NaNs, subnormals, halves, large
// exponents) are queued first, followed by random operands biased towards
// exponents where rounding actually happens. Both handshakes see random gaps.
`timescale 1ns / 1ps
module double_round_to_integral_core_tb;
  import drti_pkg::*;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_ready_o;
  logic [1:0]  action_i;
  logic [63:0] value_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic [63:0] result_o;

  typedef struct packed {
    mode_e       mode;
    logic [63:0] operand;
  } operand_t;

  operand_t    pending_q[$];
  logic [63:0] rounded_q[$];
  int          mismatches;
  int          gap_cnt;
  int          stall_cnt;
  bit          pause_done;
  bit          in_taken;

  double_round_to_integral_core DUT (.*);

  // Compute the integral value selected by the mode
  function automatic logic [63:0] round_to_integral(mode_e mode, logic [63:0] x);
    logic        neg;
    logic [63:0] fmask;
    logic [63:0] intpart;
    int          e;
    bit          up;
    neg = x[63];
    e   = int'(x[62:52]) - 1023;
    if ((x & ~SignBit) == '0) return x;
    if (x[62:52] == ExpMax) return ((x & FracMask) != '0) ? CanonNan : x;
    if (e >= 52) return x;
    if (e < 0) begin
      case (mode)
        ModeFloor: return neg ? (SignBit | OneBits) : 64'd0;
        ModeCeil:  return neg ? SignBit : OneBits;
        ModeTrunc: return x & SignBit;
        default:   return (e == -1) ? ((x & SignBit) | OneBits) : (x & SignBit);
      endcase
    end
    fmask = FracMask >> e;
    if ((x & fmask) == '0) return x;
    intpart = x & ~fmask;
    case (mode)
      ModeFloor: up = neg;
      ModeCeil:  up = !neg;
      ModeTrunc: up = 1'b0;
      default:   up = (x & (HalfBit >> e)) != '0;
    endcase
    if (up) intpart += 64'd1 << (52 - e);
    return intpart;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(5, 30);
  endfunction

  function automatic logic [63:0] random_operand();
    logic [63:0] v;
    int          r;
    v = {$urandom, $urandom};
    r = $urandom_range(0, 9);
    // Bias the exponent into the fractional range most of the time
    if (r < 7) v[62:52] = 11'(1023 + $urandom_range(0, 53) - 2);
    else if (r == 7) v[62:52] = '0;
    else if (r == 8) v[62:52] = ExpMax;
    return v;
  endfunction

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Queue directed then random operands
  initial begin
    logic [63:0] specials[$];
    specials = '{64'h0, SignBit, 64'h7FF0_0000_0000_0000, 64'hFFF0_0000_0000_0000,
                 64'h7FF0_0000_0000_0001, 64'hFFFF_FFFF_FFFF_FFFF, 64'h0000_0000_0000_0001,
                 64'h3FE0_0000_0000_0000, 64'hBFDF_FFFF_FFFF_FFFF, 64'h3FF8_0000_0000_0000,
                 64'hC004_0000_0000_0000, 64'h4330_0000_0000_0001, 64'h432F_FFFF_FFFF_FFFF,
                 64'hC32F_FFFF_FFFF_FFFF, 64'h3FF0_0000_0000_0000, 64'h7FEF_FFFF_FFFF_FFFF};
    foreach (specials[i])
      for (int m = 0; m < 4; m++)
        if (i < 6 || m == i % 4 || i >= 7) pending_q.push_back('{mode_e'(m), specials[i]});
    for (int i = 0; i < 1500; i++)
      pending_q.push_back('{mode_e'($urandom_range(0, 3)), random_operand()});
  end

  // Record each accepted operand beat and its prediction
  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && in_ready_o) begin
      rounded_q.push_back(round_to_integral(mode_e'(action_i), value_i));
      void'(pending_q.pop_front());
      in_taken = 1'b1;
    end
  end

  // Drive operand beats at the falling edge
  always @(negedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      action_i   <= '0;
      value_i    <= '0;
      gap_cnt    <= 0;
      in_taken   = 1'b0;
    end else if (!in_valid_i || in_taken) begin
      in_taken = 1'b0;
      if (pending_q.size() == 400 && !pause_done) begin
        // Hold off until every outstanding result has drained
        in_valid_i <= 1'b0;
        if (rounded_q.size() == 0) pause_done = 1'b1;
      end else if (gap_cnt > 0) begin
        in_valid_i <= 1'b0;
        gap_cnt    <= gap_cnt - 1;
      end else if (pending_q.size() > 0) begin
        in_valid_i <= 1'b1;
        action_i   <= pending_q[0].mode;
        value_i    <= pending_q[0].operand;
        gap_cnt    <= pick_gap();
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Stall the result side at random
  always @(negedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      stall_cnt   <= 0;
    end else if (stall_cnt > 0) begin
      out_ready_i <= 1'b0;
      stall_cnt   <= stall_cnt - 1;
    end else begin
      out_ready_i <= 1'b1;
      if ($urandom_range(0, 3) == 0) stall_cnt <= pick_gap();
    end
  end

  // Compare each result beat with the oldest prediction
  always @(posedge clk_i) begin
    logic [63:0] want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (rounded_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h", result_o);
      end else begin
        want = rounded_q.pop_front();
        if (result_o !== want) begin
          mismatches++;
          if (mismatches <= 10) $display("result mismatch: expected %h actual %h", want, result_o);
        end
      end
    end
  end

  initial begin
    mismatches = 0;
    pause_done = 1'b0;
    rst_ni     = 1'b0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    wait (pending_q.size() == 0 && !in_valid_i);
    wait (rounded_q.size() == 0);
    repeat (20) @(posedge clk_i);
    if (mismatches == 0 && rounded_q.size() == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end

  initial begin
    #2_000_000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule
